### design/bgv_pkg.sv
// Shared types, constants and the voltage table of the battery gauge.
package bgv_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int SV_W = 16;
	localparam int MV_W = 14;
	localparam int VOLT_W = 12;
	localparam int IDX_W = 4;
	localparam int CAP_W = 7;
	localparam int LED_W = 8;
	localparam int THR_W = 12;
	localparam int LIM_W = 8;
	localparam int CNT_W = 3;
	localparam int QUO_W = 4;
	localparam int DIVD_W = 12;
	localparam int DSR_W = 8;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam int OUT_TDATA_W = 24;

	localparam logic [MV_W-1:0] MV_FACTOR = 14'd13299;
	localparam logic [IDX_W-1:0] IDX_LAST = 4'd11;
	localparam logic [CAP_W-1:0] CAP_FULL = 7'd100;
	localparam logic [CNT_W-1:0] CNT_CONFIRM = 3'd3;
	localparam logic [CNT_W-1:0] CNT_LIMIT = 3'd2;

	localparam logic [CFG_ADDR_W-1:0] CFG_JUMP_THRESHOLD = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE_LIMIT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_LOW_POWER_LEVEL = 2'd2;

	localparam logic [THR_W-1:0] JUMP_THRESHOLD_RST = 12'd50;
	localparam logic [LIM_W-1:0] SETTLE_LIMIT_RST = 8'd10;
	localparam logic [CAP_W-1:0] LOW_POWER_LEVEL_RST = 7'd20;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILT,
		ST_CHECK,
		ST_MULT,
		ST_SEARCH,
		ST_DIV,
		ST_CAP,
		ST_PROT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic filt;
		logic mult;
		logic search;
		logic div_step;
		logic cap_write;
		logic prot;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic batt;
		logic est_needed;
		logic found;
		logic need_div;
		logic div_last;
		logic out_busy;
	} status_t;

	// Battery voltage in millivolts at each tenth of capacity, full to empty.
	function automatic logic [VOLT_W-1:0] volt_at(input logic [IDX_W-1:0] idx);
		logic [VOLT_W-1:0] v;
		unique case (idx)
			4'd0: v = 12'd4090;
			4'd1: v = 12'd4000;
			4'd2: v = 12'd3920;
			4'd3: v = 12'd3850;
			4'd4: v = 12'd3780;
			4'd5: v = 12'd3720;
			4'd6: v = 12'd3690;
			4'd7: v = 12'd3640;
			4'd8: v = 12'd3600;
			4'd9: v = 12'd3570;
			4'd10: v = 12'd3350;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### design/bgv_ctrl.sv
// Sequencing state machine of the battery gauge.
module bgv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  bgv_pkg::status_t status,
	output bgv_pkg::cmd_t    cmd
);

	bgv_pkg::state_t state_q;
	bgv_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bgv_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			bgv_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_n = bgv_pkg::ST_FILT;
				end
			end
			bgv_pkg::ST_FILT: begin
				if (status.batt) begin
					cmd.filt = 1'b1;
					state_n = bgv_pkg::ST_CHECK;
				end else begin
					state_n = bgv_pkg::ST_PROT;
				end
			end
			bgv_pkg::ST_CHECK: begin
				state_n = status.est_needed ? bgv_pkg::ST_MULT : bgv_pkg::ST_PROT;
			end
			bgv_pkg::ST_MULT: begin
				cmd.mult = 1'b1;
				state_n = bgv_pkg::ST_SEARCH;
			end
			bgv_pkg::ST_SEARCH: begin
				cmd.search = 1'b1;
				if (status.found) begin
					state_n = status.need_div ? bgv_pkg::ST_DIV : bgv_pkg::ST_CAP;
				end
			end
			bgv_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_n = bgv_pkg::ST_CAP;
				end
			end
			bgv_pkg::ST_CAP: begin
				cmd.cap_write = 1'b1;
				state_n = bgv_pkg::ST_PROT;
			end
			bgv_pkg::ST_PROT: begin
				cmd.prot = 1'b1;
				state_n = bgv_pkg::ST_OUT;
			end
			bgv_pkg::ST_OUT: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_n = bgv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = bgv_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### design/bgv_datapath.sv
// Filter, scaling, table walk, divider, protection counters and output register.
module bgv_datapath #(
	parameter int ADC_BITS = bgv_pkg::ADC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bgv_pkg::cmd_t                      cmd,
	output bgv_pkg::status_t                   status,
	input  logic                               in_batt,
	input  logic [ADC_BITS-1:0]                in_sample,
	input  logic                               cfg_wr_en,
	input  logic [bgv_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [bgv_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bgv_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                               m_tuser
);

	localparam int PROD_W = bgv_pkg::SV_W + bgv_pkg::MV_W;

	logic [bgv_pkg::THR_W-1:0] jump_thr_q;
	logic [bgv_pkg::LIM_W-1:0] settle_lim_q;
	logic [bgv_pkg::CAP_W-1:0] low_lvl_q;

	logic                       batt_q;
	logic [ADC_BITS-1:0]        sample_q;
	logic [bgv_pkg::SV_W-1:0]   sv_q;
	logic [bgv_pkg::LIM_W-1:0]  settle_q;
	logic [bgv_pkg::IDX_W-1:0]  idx_q;
	logic [bgv_pkg::DIVD_W-1:0] rem_q;
	logic [bgv_pkg::DSR_W-1:0]  dsr_q;
	logic [bgv_pkg::QUO_W-1:0]  quo_q;
	logic [1:0]                 step_q;
	logic [bgv_pkg::CAP_W-1:0]  cap_q;
	logic [bgv_pkg::LED_W-1:0]  led_q;
	logic                       done_q;
	logic [bgv_pkg::CNT_W-1:0]  low_cnt_q;
	logic [bgv_pkg::CNT_W-1:0]  norm_cnt_q;
	logic                       dsent_q;
	logic                       protect_q;
	logic                       dorm_q;

	logic [bgv_pkg::SV_W-1:0]   samp_ext;
	logic [bgv_pkg::SV_W-1:0]   diff;
	logic [bgv_pkg::SV_W-1:0]   avg;
	logic [PROD_W-1:0]          prod;
	logic [bgv_pkg::VOLT_W-1:0] v_lo;
	logic [bgv_pkg::VOLT_W-1:0] v_hi;
	logic [bgv_pkg::SV_W-1:0]   span;
	logic [bgv_pkg::DIVD_W-1:0] num;
	logic [bgv_pkg::VOLT_W-1:0] width_v;
	logic [bgv_pkg::DIVD_W-1:0] dsr_sh;
	logic [bgv_pkg::IDX_W-1:0]  tens;
	logic [bgv_pkg::CNT_W-1:0]  low_cnt_n;
	logic [bgv_pkg::CNT_W-1:0]  norm_cnt_n;
	logic                       found;

	always_comb begin
		samp_ext = bgv_pkg::SV_W'(sample_q);
		diff = (samp_ext > sv_q) ? samp_ext - sv_q : sv_q - samp_ext;
		avg = (sv_q >> 1) + (samp_ext >> 1);
		prod = PROD_W'(sv_q) * PROD_W'(bgv_pkg::MV_FACTOR);
		v_lo = bgv_pkg::volt_at(idx_q);
		v_hi = bgv_pkg::volt_at(idx_q - 4'd1);
		span = sv_q - bgv_pkg::SV_W'(v_lo);
		num = (bgv_pkg::DIVD_W'(span[7:0]) << 3) + (bgv_pkg::DIVD_W'(span[7:0]) << 1);
		width_v = v_hi - v_lo;
		dsr_sh = bgv_pkg::DIVD_W'(dsr_q) << step_q;
		tens = 4'd10 - idx_q;
		found = (idx_q == bgv_pkg::IDX_LAST) || (sv_q > bgv_pkg::SV_W'(v_lo));
		if (cap_q < low_lvl_q) begin
			low_cnt_n = low_cnt_q + 3'd1;
			norm_cnt_n = '0;
		end else begin
			low_cnt_n = '0;
			norm_cnt_n = norm_cnt_q + 3'd1;
		end
	end

	always_comb begin
		status.batt = batt_q;
		status.est_needed = settle_q > settle_lim_q;
		status.found = found;
		status.need_div = (idx_q != '0) && (idx_q != bgv_pkg::IDX_LAST);
		status.div_last = step_q == 2'd0;
		status.out_busy = m_tvalid && !m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_thr_q <= bgv_pkg::JUMP_THRESHOLD_RST;
			settle_lim_q <= bgv_pkg::SETTLE_LIMIT_RST;
			low_lvl_q <= bgv_pkg::LOW_POWER_LEVEL_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				bgv_pkg::CFG_JUMP_THRESHOLD: jump_thr_q <= cfg_wdata;
				bgv_pkg::CFG_SETTLE_LIMIT: settle_lim_q <= cfg_wdata[bgv_pkg::LIM_W-1:0];
				bgv_pkg::CFG_LOW_POWER_LEVEL: low_lvl_q <= cfg_wdata[bgv_pkg::CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q <= '0;
			settle_q <= '0;
			cap_q <= bgv_pkg::CAP_FULL;
			low_cnt_q <= '0;
			norm_cnt_q <= '0;
			dsent_q <= 1'b0;
			protect_q <= 1'b0;
			dorm_q <= 1'b0;
			done_q <= 1'b0;
			led_q <= '0;
		end else begin
			if (cmd.load_in) begin
				done_q <= 1'b0;
				led_q <= '0;
				dorm_q <= 1'b0;
			end
			if (cmd.filt) begin
				if (diff > bgv_pkg::SV_W'(jump_thr_q)) begin
					sv_q <= samp_ext;
					settle_q <= '0;
				end else begin
					sv_q <= avg;
					settle_q <= settle_q + 8'd1;
				end
			end
			if (cmd.mult) begin
				sv_q <= bgv_pkg::SV_W'(prod >> (ADC_BITS + 1));
				settle_q <= '0;
			end
			if (cmd.cap_write) begin
				done_q <= 1'b1;
				led_q <= ({idx_q, 4'b0000} - bgv_pkg::LED_W'(idx_q)) + 8'd10;
				if (idx_q == '0) begin
					cap_q <= bgv_pkg::CAP_FULL;
				end else if (idx_q == bgv_pkg::IDX_LAST) begin
					cap_q <= '0;
				end else begin
					cap_q <= (bgv_pkg::CAP_W'(tens) << 3) + (bgv_pkg::CAP_W'(tens) << 1)
						+ bgv_pkg::CAP_W'(quo_q);
				end
			end
			if (cmd.prot) begin
				if (batt_q) begin
					if (low_cnt_n > bgv_pkg::CNT_LIMIT) begin
						protect_q <= 1'b1;
						low_cnt_q <= bgv_pkg::CNT_CONFIRM;
						norm_cnt_q <= norm_cnt_n;
						if (!dsent_q) begin
							dsent_q <= 1'b1;
							dorm_q <= 1'b1;
						end
					end else if (norm_cnt_n > bgv_pkg::CNT_LIMIT) begin
						protect_q <= 1'b0;
						norm_cnt_q <= bgv_pkg::CNT_CONFIRM;
						low_cnt_q <= low_cnt_n;
						dsent_q <= 1'b0;
					end else begin
						low_cnt_q <= low_cnt_n;
						norm_cnt_q <= norm_cnt_n;
					end
				end else begin
					cap_q <= bgv_pkg::CAP_FULL;
					protect_q <= 1'b0;
					dsent_q <= 1'b0;
				end
			end
		end
	end

	// Input capture, table walk and restoring division registers.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			batt_q <= in_batt;
			sample_q <= in_sample;
		end
		if (cmd.mult) begin
			idx_q <= '0;
		end
		if (cmd.search) begin
			if (found) begin
				rem_q <= num;
				dsr_q <= width_v[bgv_pkg::DSR_W-1:0];
				quo_q <= '0;
				step_q <= 2'd3;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
		if (cmd.div_step) begin
			step_q <= step_q - 2'd1;
			if (rem_q >= dsr_sh) begin
				rem_q <= rem_q - dsr_sh;
				quo_q[step_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= bgv_pkg::OUT_TDATA_W'({dorm_q, protect_q, led_q, cap_q});
			m_tuser <= done_q;
		end
	end

endmodule

### design/battery_gauge_from_voltage_core.sv
// Top level of the battery capacity gauge driven by the divider voltage.
//
// Each request on the slave stream is one periodic check: tuser carries the
// on-battery flag and tdata the raw converter sample. Exactly one result
// leaves on the master stream for every request accepted, in order.
// The configuration port takes a write whenever cfg_wr_en is high; it should
// be used only while no check is in progress.
// A request is taken only while the sequencer is idle. Off battery a check
// steps through the filter, protection and output states; on battery
// without an estimate it adds a check state. A check that makes an estimate
// then scales the sample, walks the voltage table one entry per cycle and,
// unless the first or last entry is found, runs a four-step divider.
// The result is offered in the same cycle as the sequencer turns idle.
// The result is held in an output register, so a new request is accepted
// while the previous result still waits; when the receiver stalls, the
// sequencer waits in its final step until that register is free.
// Reset clears the filter and counters, sets the capacity to full and loads
// the default register values.
module battery_gauge_from_voltage_core #(
	parameter int ADC_BITS = bgv_pkg::ADC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0: adc_sample, zero fill.
	input  logic [((ADC_BITS+7)/8)*8-1:0]   s_tdata,
	// Fields from bit 0: on_battery.
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0: capacity_percent, led_code, low_power_protect,
	// dormancy_request, zero fill.
	output logic [bgv_pkg::OUT_TDATA_W-1:0] m_tdata,
	// Fields from bit 0: estimate_done.
	output logic                            m_tuser,
	input  logic                            cfg_wr_en,
	input  logic [bgv_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [bgv_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	bgv_pkg::cmd_t    cmd;
	bgv_pkg::status_t status;

	bgv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bgv_datapath #(
		.ADC_BITS (ADC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_batt   (s_tuser),
		.in_sample (s_tdata[ADC_BITS-1:0]),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### design/bgv_checker.sv
// Port-level assertions for the battery gauge, bound to the top level.
module bgv_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bgv_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser
);

	// A stalled result must stay on offer.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// The capacity never exceeds full.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:0] <= 7'd100)
		else $error("capacity above 100 percent");

	// A dormancy request only comes with protection active.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> m_tdata[15])
		else $error("dormancy request without protection");

	// Without a new estimate the LED code is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[14:7] == 8'd0)
		else $error("LED code present without an estimate");

endmodule

bind battery_gauge_from_voltage_core bgv_checker u_bgv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### sim/tb_battery_gauge_from_voltage_core.sv
// Self-checking testbench for the battery gauge core, with a scoreboard class.
`timescale 1ns / 1ps

module tb_battery_gauge_from_voltage_core;

	localparam int ADC_BITS = bgv_pkg::ADC_BITS_DEF;
	localparam int S_W = ((ADC_BITS + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [bgv_pkg::CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [bgv_pkg::CAP_W-1:0] capacity;
		logic done;
		logic [bgv_pkg::LED_W-1:0] led;
		logic protect;
		logic dormancy;
	} gauge_result_t;

	class gauge_scoreboard;
		logic [bgv_pkg::THR_W-1:0] jump_thr;
		logic [bgv_pkg::LIM_W-1:0] settle_lim;
		logic [bgv_pkg::CAP_W-1:0] low_level;
		logic [bgv_pkg::SV_W-1:0] smoothed;
		logic [7:0] settle_cnt;
		logic [bgv_pkg::CNT_W-1:0] low_cnt;
		logic [bgv_pkg::CNT_W-1:0] normal_cnt;
		logic dorm_sent;
		logic [bgv_pkg::CAP_W-1:0] capacity;
		logic protect;
		int unsigned volt_mv [11];
		int mv_shift;
		gauge_result_t awaited [$];
		int mismatches;
		int requests;
		int results_seen;
		int estimates;
		int dorm_pulses;
		int protect_checks;

		function new(int adc_bits);
			volt_mv = '{4090, 4000, 3920, 3850, 3780, 3720, 3690, 3640, 3600, 3570,
				3350};
			mv_shift = adc_bits + 1;
			jump_thr = 12'd50;
			settle_lim = 8'd10;
			low_level = 7'd20;
			smoothed = '0;
			settle_cnt = '0;
			low_cnt = '0;
			normal_cnt = '0;
			dorm_sent = 1'b0;
			capacity = 7'd100;
			protect = 1'b0;
			mismatches = 0;
			requests = 0;
			results_seen = 0;
			estimates = 0;
			dorm_pulses = 0;
			protect_checks = 0;
		endfunction

		function void set_reg(logic [bgv_pkg::CFG_ADDR_W-1:0] idx,
				logic [bgv_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				bgv_pkg::CFG_JUMP_THRESHOLD: jump_thr = val[bgv_pkg::THR_W-1:0];
				bgv_pkg::CFG_SETTLE_LIMIT: settle_lim = val[bgv_pkg::LIM_W-1:0];
				bgv_pkg::CFG_LOW_POWER_LEVEL: low_level = val[bgv_pkg::CAP_W-1:0];
				default: ;
			endcase
		endfunction

		function gauge_result_t gauge_step(logic batt, logic [11:0] sample);
			gauge_result_t r;
			int diff;
			logic [31:0] prod;
			logic [15:0] mv;
			int idx;
			int hi;
			int lo;
			r = '0;
			if (batt) begin
				diff = (int'(sample) > int'(smoothed)) ? int'(sample) - int'(smoothed)
					: int'(smoothed) - int'(sample);
				if (diff > int'(jump_thr)) begin
					smoothed = 16'(sample);
					settle_cnt = '0;
				end else begin
					smoothed = (smoothed >> 1) + 16'(sample >> 1);
					settle_cnt = settle_cnt + 8'd1;
				end
				if (settle_cnt > settle_lim) begin
					prod = 32'(smoothed) * 32'd13299;
					mv = 16'(prod >> mv_shift);
					smoothed = mv;
					idx = 11;
					for (int i = 10; i >= 0; i--)
						if (int'(mv) > volt_mv[i])
							idx = i;
					if (idx == 0) begin
						capacity = 7'd100;
					end else if (idx < 11) begin
						hi = volt_mv[idx - 1];
						lo = volt_mv[idx];
						capacity = 7'((10 - idx) * 10 + (int'(mv) - lo) * 10 / (hi - lo));
					end else begin
						capacity = 7'd0;
					end
					r.led = 8'(15 * idx + 10);
					r.done = 1'b1;
					settle_cnt = '0;
				end
				if (capacity < low_level) begin
					low_cnt = low_cnt + 3'd1;
					normal_cnt = '0;
				end else begin
					low_cnt = '0;
					normal_cnt = normal_cnt + 3'd1;
				end
				if (low_cnt > 3'd2) begin
					protect = 1'b1;
					low_cnt = 3'd3;
					if (!dorm_sent) begin
						dorm_sent = 1'b1;
						r.dormancy = 1'b1;
					end
				end else if (normal_cnt > 3'd2) begin
					protect = 1'b0;
					normal_cnt = 3'd3;
					dorm_sent = 1'b0;
				end
			end else begin
				capacity = 7'd100;
				protect = 1'b0;
				dorm_sent = 1'b0;
			end
			r.capacity = capacity;
			r.protect = protect;
			return r;
		endfunction

		function void note_request(logic batt, logic [11:0] sample);
			gauge_result_t r;
			r = gauge_step(batt, sample);
			awaited.push_back(r);
			requests++;
			if (r.done)
				estimates++;
			if (r.dormancy)
				dorm_pulses++;
			if (r.protect)
				protect_checks++;
		endfunction

		function void flag(string what, int want, int got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on result %0d, %s: expected %0d, got %0d",
					results_seen, what, want, got);
		endfunction

		function void check_result(gauge_result_t got);
			gauge_result_t want;
			if (awaited.size() == 0) begin
				flag("unexpected result", 0, 1);
			end else begin
				want = awaited.pop_front();
				if (got.capacity !== want.capacity)
					flag("capacity_percent", want.capacity, got.capacity);
				if (got.done !== want.done)
					flag("estimate_done", want.done, got.done);
				if (got.led !== want.led)
					flag("led_code", want.led, got.led);
				if (got.protect !== want.protect)
					flag("low_power_protect", want.protect, got.protect);
				if (got.dormancy !== want.dormancy)
					flag("dormancy_request", want.dormancy, got.dormancy);
			end
			results_seen++;
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [bgv_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_wr_en;
	logic [bgv_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [bgv_pkg::CFG_DATA_W-1:0] cfg_wdata;

	gauge_scoreboard sb;
	bit steady;
	bit hold_req;
	int hold_left;
	int cycles;

	battery_gauge_from_voltage_core #(
		.ADC_BITS(ADC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles,
				sb.pending());
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		gauge_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.capacity = m_tdata[6:0];
			got.led = m_tdata[14:7];
			got.protect = m_tdata[15];
			got.dormancy = m_tdata[16];
			got.done = m_tuser;
			sb.check_result(got);
		end
	end

	// The receiver stalls at random, or for a long stretch when asked to.
	initial begin
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 11);
			end
		end
	end

	task automatic send_check(logic batt, logic [11:0] sample);
		while (!steady && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= batt;
		s_tdata <= S_W'(sample);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(batt, sample);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [bgv_pkg::CFG_ADDR_W-1:0] idx,
			logic [bgv_pkg::CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic apply_settings(int thr, int lim, int lvl);
		s_tvalid <= 1'b0;
		drain_results();
		repeat (30) @(negedge clk);
		write_reg(bgv_pkg::CFG_JUMP_THRESHOLD, bgv_pkg::CFG_DATA_W'(thr));
		write_reg(bgv_pkg::CFG_SETTLE_LIMIT, bgv_pkg::CFG_DATA_W'(lim));
		write_reg(bgv_pkg::CFG_LOW_POWER_LEVEL, bgv_pkg::CFG_DATA_W'(lvl));
	endtask

	// Mostly settling runs around the table range, with some off-supply and jump noise.
	task automatic run_random(int n);
		int sent;
		int len;
		int base;
		int jit;
		int smp;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 9) == 0)
					base = int'($urandom_range(0, 4095));
				else
					base = int'($urandom_range(1950, 2650));
				if ($urandom_range(0, 1) == 1)
					base = base & ~1;
				len = int'(sb.settle_lim) + 2 + int'($urandom_range(0, 8));
				if (len > n - sent)
					len = n - sent;
				jit = int'(sb.jump_thr) / 4;
				if (jit > 16)
					jit = 16;
				for (int k = 0; k < len; k++) begin
					smp = base + int'($urandom_range(0, 2 * jit)) - jit;
					if (smp < 0)
						smp = 0;
					if (smp > 4095)
						smp = 4095;
					send_check(1'b1, 12'(smp));
					sent++;
				end
			end else begin
				len = int'($urandom_range(1, 4));
				if (len > n - sent)
					len = n - sent;
				for (int k = 0; k < len; k++) begin
					send_check(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
					sent++;
				end
			end
		end
	endtask

	initial begin
		int dir_batt [22];
		int dir_smp [22];
		dir_batt = '{0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1};
		dir_smp = '{0, 4095, 4095, 4095, 2060, 2061, 2060, 2060, 2060, 2400, 2400, 2400,
			2401, 0, 1, 2064, 4095, 2064, 2520, 2520, 2519, 2519};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		steady = 1'b0;
		hold_req = 1'b0;
		cycles = 0;
		sb = new(ADC_BITS);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// An index beyond the register list must leave every setting alone.
		write_reg(CFG_UNUSED, 12'd7);
		write_reg(bgv_pkg::CFG_SETTLE_LIMIT, 12'd0);
		for (int i = 0; i < 22; i++)
			send_check(1'(dir_batt[i]), 12'(dir_smp[i]));

		apply_settings(50, 10, 20);
		run_random(120);
		hold_req = 1'b1;
		run_random(130);

		apply_settings(4095, 0, 0);
		steady = 1'b1;
		run_random(150);
		steady = 1'b0;

		apply_settings(4095, 255, 127);
		run_random(300);

		apply_settings(0, 3, 100);
		run_random(150);

		apply_settings(200, 5, 60);
		run_random(150);

		s_tvalid <= 1'b0;
		drain_results();
		repeat (50) @(posedge clk);
		if (sb.pending() != 0)
			sb.flag("results never delivered", sb.pending(), 0);
		$display("Checked %0d requests against %0d results, %0d of them table estimates.",
			sb.requests, sb.results_seen, sb.estimates);
		$display("Six register settings, %0d protected checks and %0d dormancy pulses;",
			sb.protect_checks, sb.dorm_pulses);
		$display("%0d mismatches.", sb.mismatches);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
